### src/mi4_pkg.sv
`default_nettype none
package mi4_pkg;

  // Bits of the multiplier operand consumed per multiply cycle.
  localparam int DIGIT_BITS = 8;

  typedef enum logic [2:0] {
    F_LOAD,
    F_RD_A,
    F_RD_B,
    F_CAP_B,
    F_MUL,
    F_ACC,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_CHECK,
    B_DIV,
    B_ROUND
  } back_state_t;

  // Micro-steps of one cofactor term and of the determinant update.
  typedef enum logic [1:0] {
    STEP_PAIR_POS,
    STEP_PAIR_NEG,
    STEP_MINOR,
    STEP_DET
  } step_t;

  // n-th index out of 0..3 that skips idx.
  function automatic logic [1:0] skip_index(logic [1:0] idx, logic [1:0] n);
    return n + ((n >= idx) ? 2'd1 : 2'd0);
  endfunction

endpackage
`default_nettype wire

### src/mi4_ram.sv
`default_nettype none
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/mi4_fifo.sv
`default_nettype none
module mi4_fifo #(
  parameter int WIDTH = 98
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      // count moves only when exactly one side acts
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### src/mi4_front.sv
`default_nettype none
module mi4_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load_valid,
  input  wire logic [DATA_WIDTH-1:0]       load_data,
  output logic                             front_busy,
  output logic                             push,
  output logic      [3*DATA_WIDTH+1:0]     push_data,
  input  wire logic                        fifo_full,
  output logic      [4*DATA_WIDTH+1:0]     det,
  output logic                             det_zero
);

  localparam int W   = DATA_WIDTH;
  localparam int TW  = 2 * W + 1;
  localparam int CW  = 3 * W + 2;
  localparam int DW  = 4 * W + 2;
  localparam int DB  = mi4_pkg::DIGIT_BITS;
  localparam int ND  = (W + DB - 1) / DB;
  localparam int DCW = (ND > 1) ? $clog2(ND) : 1;

  mi4_pkg::front_state_t fstate, fstate_next;
  mi4_pkg::step_t        step;

  logic [3:0]     load_count;
  logic [3:0]     ci;
  logic           out_phase;
  logic [1:0]     jj;
  logic           a_neg;
  logic [W-1:0]   amag;
  logic [DW-1:0]  bsh;
  logic [DW-1:0]  prod;
  logic [DCW-1:0] dcnt;
  logic [TW-1:0]  tval;
  logic [CW-1:0]  sval;

  logic [1:0]     col, row, c0, c1, c2, r0, r1, r2, xc, yc, cj;
  logic [3:0]     addr_a, addr_b, raddr;
  logic [W-1:0]   rdata;
  logic [W-1:0]   rd_abs;
  logic           term_neg;
  logic [DW-1:0]  pval;
  logic signed [DW+DB:0] pp;

  mi4_ram #(.WIDTH(W), .DEPTH(16)) u_store (
    .clk   (clk),
    .we    (load_valid),
    .waddr (load_count),
    .wdata (load_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Cofactor coordinates and operand addresses (element address is col*4+row).
  always_comb begin
    col = ci[1:0];
    row = ci[3:2];
    c0  = mi4_pkg::skip_index(col, 2'd0);
    c1  = mi4_pkg::skip_index(col, 2'd1);
    c2  = mi4_pkg::skip_index(col, 2'd2);
    r0  = mi4_pkg::skip_index(row, 2'd0);
    r1  = mi4_pkg::skip_index(row, 2'd1);
    r2  = mi4_pkg::skip_index(row, 2'd2);
    xc  = (jj == 2'd0) ? c1 : c0;
    yc  = (jj == 2'd2) ? c1 : c2;
    cj  = (jj == 2'd0) ? c0 : ((jj == 2'd1) ? c1 : c2);
    unique case (step)
      mi4_pkg::STEP_PAIR_POS: begin
        addr_a = {xc, r1};
        addr_b = {yc, r2};
      end
      mi4_pkg::STEP_PAIR_NEG: begin
        addr_a = {xc, r2};
        addr_b = {yc, r1};
      end
      mi4_pkg::STEP_MINOR: begin
        addr_a = {cj, r0};
        addr_b = {cj, r0};
      end
      default: begin
        addr_a = {col, 2'd0};
        addr_b = {col, 2'd0};
      end
    endcase
    raddr = (fstate == mi4_pkg::F_RD_A) ? addr_a : addr_b;

    case (step)
      mi4_pkg::STEP_PAIR_NEG: term_neg = 1'b1;
      mi4_pkg::STEP_MINOR:    term_neg = (jj == 2'd1) ^ col[0] ^ row[0];
      default:                term_neg = 1'b0;
    endcase
    term_neg = term_neg ^ a_neg;
    pval     = term_neg ? (~prod + 1'b1) : prod;
    rd_abs   = rdata[W-1] ? (~rdata + 1'b1) : rdata;
    pp       = $signed(bsh) * $signed({1'b0, amag[DB-1:0]});
  end

  assign front_busy = (fstate != mi4_pkg::F_LOAD);
  assign push       = (fstate == mi4_pkg::F_PUSH) && !fifo_full;
  assign push_data  = sval;
  assign det_zero   = (det == '0);

  always_comb begin
    fstate_next = fstate;
    unique case (fstate)
      mi4_pkg::F_LOAD: begin
        if (load_valid && load_count == 4'd15) begin
          fstate_next = mi4_pkg::F_RD_A;
        end
      end
      mi4_pkg::F_RD_A: fstate_next = mi4_pkg::F_RD_B;
      mi4_pkg::F_RD_B: begin
        if (step == mi4_pkg::STEP_MINOR || step == mi4_pkg::STEP_DET) begin
          fstate_next = mi4_pkg::F_MUL;
        end else begin
          fstate_next = mi4_pkg::F_CAP_B;
        end
      end
      mi4_pkg::F_CAP_B: fstate_next = mi4_pkg::F_MUL;
      mi4_pkg::F_MUL: begin
        if (dcnt == DCW'(ND - 1)) begin
          fstate_next = mi4_pkg::F_ACC;
        end
      end
      mi4_pkg::F_ACC: begin
        if (step == mi4_pkg::STEP_MINOR && jj == 2'd2 && out_phase) begin
          fstate_next = mi4_pkg::F_PUSH;
        end else begin
          fstate_next = mi4_pkg::F_RD_A;
        end
      end
      mi4_pkg::F_PUSH: begin
        if (!fifo_full) begin
          fstate_next = (ci == 4'd15) ? mi4_pkg::F_LOAD : mi4_pkg::F_RD_A;
        end
      end
      default: fstate_next = mi4_pkg::F_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= mi4_pkg::F_LOAD;
    end else begin
      fstate <= fstate_next;
    end
  end

  // Sequencer counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= 4'd0;
      ci         <= 4'd0;
      out_phase  <= 1'b0;
      jj         <= 2'd0;
      step       <= mi4_pkg::STEP_PAIR_POS;
    end else begin
      if (load_valid) begin
        load_count <= load_count + 4'd1;
      end
      if (fstate == mi4_pkg::F_ACC) begin
        unique case (step)
          mi4_pkg::STEP_PAIR_POS: step <= mi4_pkg::STEP_PAIR_NEG;
          mi4_pkg::STEP_PAIR_NEG: step <= mi4_pkg::STEP_MINOR;
          mi4_pkg::STEP_MINOR: begin
            if (jj != 2'd2) begin
              jj   <= jj + 2'd1;
              step <= mi4_pkg::STEP_PAIR_POS;
            end else if (!out_phase) begin
              step <= mi4_pkg::STEP_DET;
            end
          end
          default: begin
            jj   <= 2'd0;
            step <= mi4_pkg::STEP_PAIR_POS;
            if (ci == 4'd3) begin
              ci        <= 4'd0;
              out_phase <= 1'b1;
            end else begin
              ci <= ci + 4'd1;
            end
          end
        endcase
      end
      if (push) begin
        jj   <= 2'd0;
        step <= mi4_pkg::STEP_PAIR_POS;
        ci   <= ci + 4'd1;
        if (ci == 4'd15) begin
          out_phase <= 1'b0;
        end
      end
    end
  end

  // Shared multiply-accumulate datapath.
  always_ff @(posedge clk) begin
    unique case (fstate)
      mi4_pkg::F_RD_B: begin
        a_neg <= rdata[W-1];
        amag  <= rd_abs;
        prod  <= '0;
        dcnt  <= '0;
        if (step == mi4_pkg::STEP_MINOR) begin
          bsh <= {{(DW-TW){tval[TW-1]}}, tval};
        end else begin
          bsh <= {{(DW-CW){sval[CW-1]}}, sval};
        end
      end
      mi4_pkg::F_CAP_B: begin
        bsh <= {{(DW-W){rdata[W-1]}}, rdata};
      end
      mi4_pkg::F_MUL: begin
        prod <= prod + pp[DW-1:0];
        bsh  <= bsh << DB;
        amag <= amag >> DB;
        dcnt <= dcnt + 1'b1;
      end
      mi4_pkg::F_ACC: begin
        unique case (step)
          mi4_pkg::STEP_PAIR_POS: tval <= pval[TW-1:0];
          mi4_pkg::STEP_PAIR_NEG: tval <= tval + pval[TW-1:0];
          mi4_pkg::STEP_MINOR: begin
            if (jj == 2'd0) begin
              sval <= pval[CW-1:0];
            end else begin
              sval <= sval + pval[CW-1:0];
            end
          end
          default: begin
            if (ci == 4'd0) begin
              det <= pval;
            end else begin
              det <= det + pval;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### src/mi4_back.sv
`default_nettype none
module mi4_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fifo_empty,
  output logic                           pop,
  input  wire logic [3*DATA_WIDTH+1:0]   pop_data,
  input  wire logic [4*DATA_WIDTH+1:0]   det,
  input  wire logic                      det_zero,
  output logic                           back_busy,
  output logic                           result_strobe,
  output logic signed [DATA_WIDTH-1:0]   inverse_value,
  output logic                           singular,
  output logic                           saturated,
  output logic                           last
);

  localparam int W   = DATA_WIDTH;
  localparam int CW  = 3 * W + 2;
  localparam int DW  = 4 * W + 2;
  localparam int QB  = W + 1;
  localparam int NW  = CW + 2 * FRAC_BITS;
  localparam int DQ  = DW + QB;
  localparam int XW  = (NW > DQ) ? NW : DQ;
  localparam int CNW = $clog2(QB);
  localparam bit ONE_SAT = (FRAC_BITS >= DATA_WIDTH - 1);
  localparam logic [W-1:0] ONE_VAL =
    ONE_SAT ? {1'b0, {(W-1){1'b1}}} : (W'(1) << FRAC_BITS);
  localparam logic [W+1:0] LIM_NEG = (W+2)'(1) << (W - 1);
  localparam logic [W+1:0] LIM_POS = LIM_NEG - (W+2)'(1);

  mi4_pkg::back_state_t bstate, bstate_next;

  logic [XW-1:0]  nm;
  logic           nneg;
  logic [DW-1:0]  dm;
  logic           qneg;
  logic           sing;
  logic           ovf;
  logic [XW-1:0]  rem;
  logic [XW-1:0]  dsh;
  logic [QB-1:0]  q;
  logic [CNW-1:0] cnt;
  logic [3:0]     k;

  logic [CW-1:0]  cmag;
  logic [DW-1:0]  dabs;
  logic           rnd;
  logic [W+1:0]   qr;
  logic [W+1:0]   lim;
  logic           sat_q;
  logic [W+1:0]   mag_o;
  logic [W-1:0]   val_q;
  logic           diag;

  always_comb begin
    cmag  = pop_data[CW-1] ? (~pop_data + 1'b1) : pop_data;
    dabs  = det[DW-1] ? (~det + 1'b1) : det;
    rnd   = ({rem, 1'b0} >= {{(XW-DW+1){1'b0}}, dm});
    qr    = {1'b0, q} + {{(W+1){1'b0}}, rnd};
    lim   = qneg ? LIM_NEG : LIM_POS;
    sat_q = ovf || (qr > lim);
    mag_o = sat_q ? lim : qr;
    val_q = qneg ? (~mag_o[W-1:0] + 1'b1) : mag_o[W-1:0];
    diag  = (k[3:2] == k[1:0]);
  end

  assign pop       = (bstate == mi4_pkg::B_IDLE) && !fifo_empty;
  assign back_busy = (bstate != mi4_pkg::B_IDLE);

  always_comb begin
    bstate_next = bstate;
    unique case (bstate)
      mi4_pkg::B_IDLE: begin
        if (!fifo_empty) begin
          bstate_next = mi4_pkg::B_SETUP;
        end
      end
      mi4_pkg::B_SETUP: begin
        bstate_next = det_zero ? mi4_pkg::B_ROUND : mi4_pkg::B_CHECK;
      end
      mi4_pkg::B_CHECK: begin
        bstate_next = (nm >= ({{(XW-DW){1'b0}}, dm} << QB)) ?
                      mi4_pkg::B_ROUND : mi4_pkg::B_DIV;
      end
      mi4_pkg::B_DIV: begin
        if (cnt == '0) begin
          bstate_next = mi4_pkg::B_ROUND;
        end
      end
      mi4_pkg::B_ROUND: bstate_next = mi4_pkg::B_IDLE;
      default:          bstate_next = mi4_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate        <= mi4_pkg::B_IDLE;
      k             <= 4'd0;
      result_strobe <= 1'b0;
    end else begin
      bstate        <= bstate_next;
      result_strobe <= (bstate == mi4_pkg::B_ROUND);
      if (bstate == mi4_pkg::B_ROUND) begin
        k <= k + 4'd1;
      end
    end
  end

  // Restoring division of |cofactor| * 2^(2F) by |det|, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    unique case (bstate)
      mi4_pkg::B_IDLE: begin
        nm   <= {{(XW-CW){1'b0}}, cmag} << (2 * FRAC_BITS);
        nneg <= pop_data[CW-1];
      end
      mi4_pkg::B_SETUP: begin
        dm   <= dabs;
        qneg <= nneg ^ det[DW-1];
        sing <= det_zero;
        ovf  <= 1'b0;
      end
      mi4_pkg::B_CHECK: begin
        ovf <= (nm >= ({{(XW-DW){1'b0}}, dm} << QB));
        rem <= nm;
        dsh <= {{(XW-DW){1'b0}}, dm} << (QB - 1);
        q   <= '0;
        cnt <= CNW'(QB - 1);
      end
      mi4_pkg::B_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[QB-2:0], 1'b1};
        end else begin
          q   <= {q[QB-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      mi4_pkg::B_ROUND: begin
        singular <= sing;
        last     <= (k == 4'd15);
        if (sing) begin
          inverse_value <= diag ? ONE_VAL : '0;
          saturated     <= diag && ONE_SAT;
        end else begin
          inverse_value <= val_q;
          saturated     <= sat_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### src/matrix4_inverse_adjugate_unit.sv
`default_nettype none
// 4x4 matrix inverter, signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction).
//
// Input: one matrix element per transaction, column-major order, accepted at a
// rising edge with start high and busy low. The first fifteen elements are only
// stored. The sixteenth starts the computation and raises busy.
//
// Output: sixteen inverse elements, column-major, each shown for exactly one
// cycle with result_strobe high; last marks the sixteenth. The receiver cannot
// stall, so the results leave at the pace the divider produces them.
// A zero determinant gives the identity with singular set; clipped values set
// saturated.
//
// The front sequencer runs every product through one shared byte-serial
// multiplier. It first computes the determinant, then the sixteen cofactors;
// each division in the back end overlaps the next cofactor through a
// two-entry queue.
// Reset (rst, synchronous) drops any matrix in flight and restarts loading
// at the first element.
module matrix4_inverse_adjugate_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [DATA_WIDTH-1:0]   element_value,
  output logic                         result_strobe,
  output logic signed [DATA_WIDTH-1:0] inverse_value,
  output logic                         singular,
  output logic                         saturated,
  output logic                         last
);

  localparam int CW = 3 * DATA_WIDTH + 2;
  localparam int DW = 4 * DATA_WIDTH + 2;

  logic          load_valid;
  logic          front_busy;
  logic          back_busy;
  logic          push;
  logic [CW-1:0] push_data;
  logic          fifo_full;
  logic          fifo_empty;
  logic          pop;
  logic [CW-1:0] pop_data;
  logic [DW-1:0] det;
  logic          det_zero;

  // Hold off new elements while any part of the current matrix is in flight.
  assign busy       = front_busy || !fifo_empty || back_busy;
  assign load_valid = start && !busy;

  // Store elements, then compute determinant and cofactors in output order.
  mi4_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_data  (element_value),
    .front_busy (front_busy),
    .push       (push),
    .push_data  (push_data),
    .fifo_full  (fifo_full),
    .det        (det),
    .det_zero   (det_zero)
  );

  // Decouple cofactor generation from division.
  mi4_fifo #(.WIDTH(CW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  // Divide each cofactor by the determinant, round, clip and emit.
  mi4_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .fifo_empty    (fifo_empty),
    .pop           (pop),
    .pop_data      (pop_data),
    .det           (det),
    .det_zero      (det_zero),
    .back_busy     (back_busy),
    .result_strobe (result_strobe),
    .inverse_value (inverse_value),
    .singular      (singular),
    .saturated     (saturated),
    .last          (last)
  );

endmodule
`default_nettype wire
